### hw/rtl/crcdf_pkg.sv
// ----------------------------------------------------------------------------
// crcdf_pkg: shared definitions for the CRC-32 record deframer
// Phase encoding, record status codes, field widths and the byte-wise
// CRC-32 update (reflected polynomial 0xEDB88320).
// ----------------------------------------------------------------------------
package crcdf_pkg;

  // Width of the stream byte counter and the total_bytes register
  localparam int unsigned TOTAL_W = 48;
  // Default width of the record length register
  localparam int unsigned LENGTH_BITS_DEF = 48;

  localparam int unsigned HDR_CRC_BYTES = 4;
  localparam int unsigned HDR_BYTES     = 12;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  // Record status reported with record_done
  typedef logic [1:0] status_t;
  localparam status_t ST_NONE    = 2'd0;
  localparam status_t ST_GOOD    = 2'd1;
  localparam status_t ST_BAD_CRC = 2'd2;
  localparam status_t ST_TRUNC   = 2'd3;

  // Deframer phase, one-hot
  typedef enum logic [3:0] {
    PH_CKSUM   = 4'b0001,
    PH_LENGTH  = 4'b0010,
    PH_PAYLOAD = 4'b0100,
    PH_HALTED  = 4'b1000
  } phase_t;

  // One byte through the reflected CRC-32 shift register
  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage

### hw/rtl/crc32_record_deframer.sv
// ----------------------------------------------------------------------------
// crc32_record_deframer: length-prefixed record stream checker with CRC-32
// Splits a byte stream into records (4-byte CRC, 8-byte length, payload),
// passes payload through and reports good, mismatched or truncated records.
// ----------------------------------------------------------------------------
// Usage: write total_bytes through cfg_we/cfg_wdata while the block is idle;
// this restarts checking. It then takes one stream byte per clock while
// in_ready is high and registers each stream byte's result in the next cycle.
// The cycle is bounded by the byte-wise CRC-32 update and the 48-bit
// length-versus-remaining compare, which sit between the input handshake and
// the result register. A byte offered after the stream is exhausted (or with
// total_bytes zero) is taken and produces no result. in_ready stays high
// while the result register is empty or being drained in the same cycle.
module crc32_record_deframer #(
  parameter int unsigned LENGTH_BITS = crcdf_pkg::LENGTH_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_we,
  input  logic [crcdf_pkg::TOTAL_W-1:0] cfg_wdata,
  // byte input
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    data_byte,
  // results
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    payload_byte,
  output logic                          payload_valid,
  output logic                          record_done,
  output crcdf_pkg::status_t            record_status,
  output logic                          stream_done,
  output logic                          stream_error
);
  import crcdf_pkg::*;

  localparam int unsigned CMP_W = (LENGTH_BITS > TOTAL_W) ? LENGTH_BITS : TOTAL_W;
  localparam logic [63:0] LEN_MASK =
    (LENGTH_BITS >= 64) ? {64{1'b1}} : ((64'd1 << LENGTH_BITS) - 64'd1);

  // State
  phase_t                 phase, phase_next;
  logic [3:0]             header_count, header_count_next;
  logic [31:0]            stored_checksum, stored_checksum_next;
  logic [LENGTH_BITS-1:0] record_length, record_length_next;
  logic                   length_overflow, length_overflow_next;
  logic [31:0]            crc_register, crc_register_next;
  logic [TOTAL_W-1:0]     remaining_bytes, remaining_bytes_next;
  logic                   error_flag, error_flag_next;

  // Result of the current byte
  logic       accept, live, last;
  logic [7:0] res_pbyte;
  logic       res_pvalid, res_done;
  status_t    res_status;

  // Header working values (start of a header clears the record fields)
  logic                   hdr_start;
  logic [31:0]            cs_base;
  logic [LENGTH_BITS-1:0] len_base;
  logic                   ovf_base;
  logic [2:0]             len_lane;
  logic [63:0]            len_wide;
  logic [31:0]            crc_new;
  logic [LENGTH_BITS-1:0] len_dec;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign live     = (remaining_bytes != '0);
  assign last     = (remaining_bytes == TOTAL_W'(1));

  assign hdr_start = (header_count == 4'd0);
  assign cs_base   = hdr_start ? 32'd0 : stored_checksum;
  assign len_base  = hdr_start ? '0 : record_length;
  assign ovf_base  = hdr_start ? 1'b0 : length_overflow;
  assign len_lane  = 3'(header_count - 4'(HDR_CRC_BYTES));
  assign len_wide  = {56'd0, data_byte} << {len_lane, 3'b000};
  assign crc_new   = crc_byte(crc_register, data_byte);
  assign len_dec   = record_length - LENGTH_BITS'(1);

  // Per-byte state update and result
  always_comb begin
    phase_next           = phase;
    header_count_next    = header_count;
    stored_checksum_next = stored_checksum;
    record_length_next   = record_length;
    length_overflow_next = length_overflow;
    crc_register_next    = crc_register;
    remaining_bytes_next = remaining_bytes - TOTAL_W'(1);
    error_flag_next      = error_flag;
    res_pbyte            = 8'd0;
    res_pvalid           = 1'b0;
    res_done             = 1'b0;
    res_status           = ST_NONE;

    if (!error_flag) begin
      case (phase)
        PH_CKSUM, PH_LENGTH: begin
          stored_checksum_next = cs_base;
          record_length_next   = len_base;
          length_overflow_next = ovf_base;
          if (hdr_start) begin
            crc_register_next = CRC_INIT;
          end
          if (header_count < 4'(HDR_CRC_BYTES)) begin
            stored_checksum_next = cs_base |
              (32'(data_byte) << {header_count[1:0], 3'b000});
          end else begin
            // length byte: bits above LENGTH_BITS must be zero
            record_length_next   = len_base | len_wide[LENGTH_BITS-1:0];
            length_overflow_next = ovf_base || ((len_wide & ~LEN_MASK) != 64'd0);
          end
          header_count_next = header_count + 4'd1;
          phase_next = (header_count_next < 4'(HDR_CRC_BYTES)) ? PH_CKSUM : PH_LENGTH;
          if (header_count_next == 4'(HDR_BYTES)) begin
            header_count_next = 4'd0;
            if (length_overflow_next ||
                (CMP_W'(record_length_next) > CMP_W'(remaining_bytes_next))) begin
              res_done        = 1'b1;
              res_status      = ST_TRUNC;
              error_flag_next = 1'b1;
              phase_next      = PH_HALTED;
            end else if (record_length_next == '0) begin
              // empty payload: CRC of no bytes is zero
              res_done = 1'b1;
              if (stored_checksum_next == 32'd0) begin
                res_status = ST_GOOD;
                phase_next = PH_CKSUM;
              end else begin
                res_status      = ST_BAD_CRC;
                error_flag_next = 1'b1;
                phase_next      = PH_HALTED;
              end
            end else begin
              phase_next = PH_PAYLOAD;
            end
          end else if (last) begin
            // stream ends inside a header
            res_done        = 1'b1;
            res_status      = ST_TRUNC;
            error_flag_next = 1'b1;
            phase_next      = PH_HALTED;
          end
        end
        PH_PAYLOAD: begin
          res_pvalid         = 1'b1;
          res_pbyte          = data_byte;
          crc_register_next  = crc_new;
          record_length_next = len_dec;
          if (len_dec == '0) begin
            res_done          = 1'b1;
            header_count_next = 4'd0;
            if (~crc_new == stored_checksum) begin
              res_status = ST_GOOD;
              phase_next = PH_CKSUM;
            end else begin
              res_status      = ST_BAD_CRC;
              error_flag_next = 1'b1;
              phase_next      = PH_HALTED;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Control and record state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_CKSUM;
      header_count    <= 4'd0;
      stored_checksum <= 32'd0;
      record_length   <= '0;
      length_overflow <= 1'b0;
      crc_register    <= CRC_INIT;
      remaining_bytes <= '0;
      error_flag      <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        // new stream length restarts checking
        phase           <= PH_CKSUM;
        header_count    <= 4'd0;
        stored_checksum <= 32'd0;
        record_length   <= '0;
        length_overflow <= 1'b0;
        crc_register    <= CRC_INIT;
        remaining_bytes <= cfg_wdata;
        error_flag      <= 1'b0;
      end else if (accept && live) begin
        phase           <= phase_next;
        header_count    <= header_count_next;
        stored_checksum <= stored_checksum_next;
        record_length   <= record_length_next;
        length_overflow <= length_overflow_next;
        crc_register    <= crc_register_next;
        remaining_bytes <= remaining_bytes_next;
        error_flag      <= error_flag_next;
      end

      if (accept && live) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (accept && live) begin
      payload_byte  <= res_pbyte;
      payload_valid <= res_pvalid;
      record_done   <= res_done;
      record_status <= res_status;
      stream_done   <= last;
      stream_error  <= error_flag_next;
    end
  end

endmodule

### hw/rtl/crcdf_checker.sv
// ----------------------------------------------------------------------------
// crcdf_checker: port-level assertions for the CRC-32 record deframer
// Watches the result channel for status coding, sticky error and end of
// stream behavior; bound to the top level below.
// ----------------------------------------------------------------------------
module crcdf_checker (
  input logic                     clk,
  input logic                     rst,
  input logic                     cfg_we,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [7:0]               payload_byte,
  input logic                     payload_valid,
  input logic                     record_done,
  input crcdf_pkg::status_t       record_status,
  input logic                     stream_done,
  input logic                     stream_error
);
  import crcdf_pkg::*;

  logic out_take;
  logic err_seen;
  logic end_seen;

  assign out_take = out_valid && out_ready;

  // Track delivered error and end-of-stream since the last restart
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      err_seen <= 1'b0;
      end_seen <= 1'b0;
    end else if (out_take) begin
      err_seen <= err_seen || stream_error;
      end_seen <= end_seen || stream_done;
    end
  end

  // A status is reported only with record_done
  a_status_only_when_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && !record_done |-> record_status == ST_NONE)
    else $error("record_status set without record_done");

  // Error flag stays set once delivered
  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && err_seen |-> stream_error)
    else $error("stream_error dropped after an error");

  // A good record never follows or carries an error
  a_good_no_error: assert property (@(posedge clk) disable iff (rst)
    out_valid && record_done && record_status == ST_GOOD |-> !stream_error)
    else $error("good record reported with error flag");

  // Nothing comes out after the last stream byte until a restart
  a_no_result_after_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_seen |-> 1'b0)
    else $error("result after end of stream");

  // A stalled result stays valid and holds its payload, status and stream_done
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(payload_byte) &&
      $stable(payload_valid) && $stable(record_status) && $stable(stream_done))
    else $error("result changed while stalled");

endmodule

bind crc32_record_deframer crcdf_checker u_crcdf_checker (
  .clk           (clk),
  .rst           (rst),
  .cfg_we        (cfg_we),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .payload_byte  (payload_byte),
  .payload_valid (payload_valid),
  .record_done   (record_done),
  .record_status (record_status),
  .stream_done   (stream_done),
  .stream_error  (stream_error)
);

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for crc32_record_deframer
// Sends record streams (CRC, length, payload) with good and corrupted
// checksums, zero lengths, oversized and truncating lengths and cut-off
// streams. Every accepted byte is predicted cycle-free by a scoreboard and
// each result is compared field by field under random source and sink stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import crcdf_pkg::*;

  localparam int unsigned LEN_W       = LENGTH_BITS_DEF;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_WAIT  = 10;

  typedef struct packed {
    logic [7:0] pbyte;
    logic       pvalid;
    logic       rdone;
    status_t    rstatus;
    logic       sdone;
    logic       serr;
  } deframe_result_t;

  // Scoreboard: tracks the deframer state and queues the expected results
  class record_scoreboard;
    phase_t                ph;
    int unsigned           hdr_cnt;
    logic [31:0]           stored_crc;
    logic [LEN_W-1:0]      rec_len;
    bit                    len_ovf;
    logic [31:0]           crc_reg;
    logic [TOTAL_W-1:0]    remaining;
    bit                    sticky_err;
    deframe_result_t       expected_results[$];
    int unsigned           errors;

    function new();
      errors = 0;
      restart('0);
    endfunction

    // Reflected CRC-32, one byte, LSB first
    static function logic [31:0] crc_next(logic [31:0] c, logic [7:0] b);
      logic [31:0] r;
      logic        lsb;
      r = c ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
        lsb = r[0];
        r   = r >> 1;
        if (lsb) r = r ^ CRC_POLY;
      end
      return r;
    endfunction

    // A write of total_bytes restarts the stream
    function void restart(logic [TOTAL_W-1:0] total);
      ph         = PH_CKSUM;
      hdr_cnt    = 0;
      stored_crc = '0;
      rec_len    = '0;
      len_ovf    = 0;
      crc_reg    = CRC_INIT;
      remaining  = total;
      sticky_err = 0;
    endfunction

    // Accepted input request: work out the result it causes, if any
    function void note_byte(logic [7:0] b);
      deframe_result_t r;
      int unsigned     pos;
      int unsigned     keep;
      logic [63:0]     part;
      if (remaining == 0) return;  // beyond the stream: no result
      remaining = remaining - 1'b1;
      r = '0;
      r.rstatus = ST_NONE;
      r.sdone = (remaining == 0);
      if (!sticky_err) begin
        case (ph)
          PH_CKSUM, PH_LENGTH: begin
            if (hdr_cnt == 0) begin
              stored_crc = '0;
              rec_len    = '0;
              len_ovf    = 0;
              crc_reg    = CRC_INIT;
            end
            if (hdr_cnt < HDR_CRC_BYTES) begin
              stored_crc[8*hdr_cnt +: 8] = b;
            end else begin
              pos = 8 * (hdr_cnt - HDR_CRC_BYTES);
              if (pos >= LEN_W) begin
                if (b != 0) len_ovf = 1;
              end else begin
                keep = LEN_W - pos;
                part = {56'd0, b};
                if (keep < 8) begin
                  if ((b >> keep) != 0) len_ovf = 1;
                  part = part & ((64'd1 << keep) - 1);
                end
                rec_len = rec_len | LEN_W'(part << pos);
              end
            end
            hdr_cnt++;
            ph = (hdr_cnt < HDR_CRC_BYTES) ? PH_CKSUM : PH_LENGTH;
            if (hdr_cnt >= HDR_BYTES) begin
              hdr_cnt = 0;
              if (len_ovf || rec_len > remaining) begin
                r.rdone = 1; r.rstatus = ST_TRUNC; sticky_err = 1; ph = PH_HALTED;
              end else if (rec_len == 0) begin
                // empty payload checks against the CRC of nothing, which is zero
                r.rdone = 1;
                if (stored_crc == 0) begin
                  r.rstatus = ST_GOOD; ph = PH_CKSUM;
                end else begin
                  r.rstatus = ST_BAD_CRC; sticky_err = 1; ph = PH_HALTED;
                end
              end else begin
                ph = PH_PAYLOAD;
              end
            end else if (r.sdone) begin
              // stream ends inside a header
              r.rdone = 1; r.rstatus = ST_TRUNC; sticky_err = 1; ph = PH_HALTED;
            end
          end
          PH_PAYLOAD: begin
            r.pvalid = 1;
            r.pbyte  = b;
            crc_reg  = crc_next(crc_reg, b);
            rec_len  = rec_len - 1'b1;
            if (rec_len == 0) begin
              r.rdone = 1;
              hdr_cnt = 0;
              if (~crc_reg == stored_crc) begin
                r.rstatus = ST_GOOD; ph = PH_CKSUM;
              end else begin
                r.rstatus = ST_BAD_CRC; sticky_err = 1; ph = PH_HALTED;
              end
            end
          end
          default: ;
        endcase
      end
      r.serr = sticky_err;
      expected_results = {expected_results, r};
    endfunction

    function void check_field(string name, logic [7:0] exp, logic [7:0] act);
      if (exp !== act) begin
        errors++;
        $display("%0t %s: expected %0h, actual %0h", $time, name, exp, act);
      end
    endfunction

    // Accepted result: compare against the oldest expectation
    function void check_result(deframe_result_t act);
      deframe_result_t exp;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none, actual %0h", $time, act);
        return;
      end
      exp = expected_results.pop_front();
      check_field("payload_byte", exp.pbyte, act.pbyte);
      check_field("payload_valid", exp.pvalid, act.pvalid);
      check_field("record_done", exp.rdone, act.rdone);
      check_field("record_status", exp.rstatus, act.rstatus);
      check_field("stream_done", exp.sdone, act.sdone);
      check_field("stream_error", exp.serr, act.serr);
    endfunction
  endclass

  logic               clk = 0;
  logic               rst = 1;
  logic               cfg_we = 0;
  logic [TOTAL_W-1:0] cfg_wdata = '0;
  logic               in_valid = 0;
  logic               in_ready;
  logic [7:0]         data_byte = '0;
  logic               out_valid;
  logic               out_ready = 0;
  logic [7:0]         payload_byte;
  logic               payload_valid;
  logic               record_done;
  status_t            record_status;
  logic               stream_done;
  logic               stream_error;

  record_scoreboard   sb;
  logic [7:0]         stream_q[$];
  int unsigned        send_idle = 0;
  int unsigned        recv_stall = 0;
  int unsigned        cycle_count = 0;

  crc32_record_deframer u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .payload_byte (payload_byte),
    .payload_valid(payload_valid),
    .record_done  (record_done),
    .record_status(record_status),
    .stream_done  (stream_done),
    .stream_error (stream_error)
  );

  always #5 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // Input side: note every accepted byte request
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) sb.note_byte(data_byte);
  end

  // Output side: check accepted results, random backpressure
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result({payload_byte, payload_valid, record_done, record_status,
                       stream_done, stream_error});
    out_ready <= ($urandom_range(99) >= recv_stall);
  end

  function automatic void set_idling(int unsigned sel);
    case (sel % 4)
      0: begin send_idle = 0;  recv_stall = 0;  end
      1: begin send_idle = 81; recv_stall = 0;  end
      2: begin send_idle = 0;  recv_stall = 81; end
      default: begin send_idle = 30; recv_stall = 30; end
    endcase
  endfunction

  // Append one byte to the stream under construction
  function automatic void queue_byte(logic [7:0] b);
    stream_q = {stream_q, b};
  endfunction

  function automatic void add_header(logic [31:0] crc, logic [63:0] len);
    for (int i = 0; i < 4; i++) queue_byte(crc[8*i +: 8]);
    for (int i = 0; i < 8; i++) queue_byte(len[8*i +: 8]);
  endfunction

  function automatic void add_random_bytes(int unsigned n);
    repeat (n) queue_byte(8'($urandom_range(255)));
  endfunction

  // Offer one byte, with random gaps ahead of it
  task automatic push_byte(logic [7:0] b);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid  <= 1;
    data_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Wait for all expected results, then a short settle pause
  task automatic wait_drained(int unsigned settle);
    @(posedge clk);
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_total(logic [TOTAL_W-1:0] v);
    wait_drained(4);
    cfg_we    <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.restart(v);
  endtask

  task automatic send_stream(logic [TOTAL_W-1:0] total, int unsigned extra);
    write_total(total);
    foreach (stream_q[i]) push_byte(stream_q[i]);
    repeat (extra) push_byte(8'($urandom));
    in_valid <= 0;
  endtask

  // Random record sequence; stops after the first record that fails
  task automatic build_records();
    int unsigned nrec, kind, plen, tail, len_at;
    logic [31:0] crc;
    logic [63:0] len;
    logic [7:0]  pay[$];
    bit          stop;
    stream_q.delete();
    stop = 0;
    nrec = $urandom_range(1, 5);
    for (int k = 0; k < nrec && !stop; k++) begin
      kind = $urandom_range(99);
      if (kind < 64) begin
        // payload record, checksum sometimes corrupted
        plen = ($urandom_range(99) < 90) ? $urandom_range(1, 16) : $urandom_range(17, 64);
        crc = CRC_INIT;
        pay.delete();
        for (int i = 0; i < plen; i++) begin
          pay = {pay, 8'($urandom_range(255))};
          crc = record_scoreboard::crc_next(crc, pay[i]);
        end
        crc = ~crc;
        if (kind >= 54) begin
          crc = crc ^ (32'h1 << $urandom_range(31));
          stop = 1;
        end
        add_header(crc, 64'(plen));
        foreach (pay[i]) queue_byte(pay[i]);
        if (stop) add_random_bytes($urandom_range(0, 4));
      end else if (kind < 76) begin
        // zero length, checksum zero or not
        crc = $urandom_range(1) ? 32'h0 : $urandom;
        add_header(crc, 64'd0);
        if (crc != 0) begin
          stop = 1;
          add_random_bytes($urandom_range(0, 4));
        end
      end else if (kind < 88) begin
        // length wider than the length register
        len = {$urandom, $urandom};
        len[LEN_W + $urandom_range(63 - LEN_W)] = 1'b1;
        add_header($urandom, len);
        stop = 1;
        add_random_bytes($urandom_range(0, 4));
      end else begin
        // length runs past the end of the stream
        len_at = stream_q.size() + HDR_CRC_BYTES;
        add_header($urandom, 64'd0);
        tail = $urandom_range(0, 6);
        add_random_bytes(tail);
        if ($urandom_range(3) == 0)
          len = 64'(tail + 1) + {17'd0, 15'($urandom), $urandom};
        else
          len = 64'(tail + 1 + $urandom_range(0, 3));
        for (int i = 0; i < 8; i++) stream_q[len_at + i] = len[8*i +: 8];
        stop = 1;
      end
    end
  endtask

  initial begin
    logic [31:0]        crc;
    logic [TOTAL_W-1:0] total;
    longint             sent;
    int unsigned        size, pick, extra, nstream;
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: empty stream, then a good record, a header cut by the stream end,
    // a byte past the end, and an oversized length on a maximal stream
    set_idling(0);
    push_byte(8'hA5);
    in_valid <= 0;
    stream_q.delete();
    send_stream('0, 1);

    stream_q.delete();
    crc = record_scoreboard::crc_next(record_scoreboard::crc_next(CRC_INIT, 8'h00), 8'hFF);
    add_header(~crc, 64'd2);
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_byte(8'h00);
    send_stream(TOTAL_W'(15), 1);

    stream_q.delete();
    add_header(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_byte(8'h3C);
    send_stream({TOTAL_W{1'b1}}, 0);

    // Random streams
    sent = 0;
    nstream = 0;
    while (sent < 900) begin
      set_idling(nstream / 2);
      build_records();
      size  = stream_q.size();
      pick  = $urandom_range(99);
      extra = 0;
      if (pick < 70) begin
        total = TOTAL_W'(size);
      end else if (pick < 85 && size > 1) begin
        total = TOTAL_W'($urandom_range(1, size - 1));
      end else if (pick < 95) begin
        total = TOTAL_W'(size);
        extra = $urandom_range(1, 4);
      end else begin
        total = TOTAL_W'({$urandom, $urandom});
        total[TOTAL_W-1] = 1'b1;
      end
      send_stream(total, extra);
      sent += (total < size) ? longint'(total) : longint'(size);
      nstream++;
    end

    wait_drained(DRAIN_WAIT);
    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

### crc32_record_deframer.f
hw/rtl/crcdf_pkg.sv
hw/rtl/crc32_record_deframer.sv
hw/rtl/crcdf_checker.sv
bench/tb_top.sv
